// ===== rtl/kmeans_cluster_engine_top_defines.svh =====
// assertion macros for the k-means cluster engine
// no dependencies; included by the top module, which checks itself
`ifndef KMEANS_CLUSTER_ENGINE_TOP_DEFINES_SVH
`define KMEANS_CLUSTER_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define KMCE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmce check failed");
`define KMCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmce check failed");
`else
`define KMCE_ASSERT_SAME(lbl, ante, cons)
`define KMCE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/kmce_pkg.sv =====
// shared types and constants of the k-means cluster engine
// no dependencies
package kmce_pkg;

  localparam int MAX_POINTS_DEF   = 1024;
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int MAX_DIMS_DEF     = 4;

  localparam int CW       = 16;
  localparam int NDIM     = 4;
  localparam int DIFW     = CW + 1;
  localparam int SQW      = 2 * DIFW;
  localparam int DISTW    = SQW + 2;
  localparam int BEST_W   = 6;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 16;

  localparam logic [1:0] KIND_CLASS  = 2'd0;
  localparam logic [1:0] KIND_CENTER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_CLUSTERS = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ITER     = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_DIMS     = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_CONV     = 3'd3;

  typedef logic signed [NDIM-1:0][CW-1:0] point_t;

  typedef struct packed {
    logic              done;
    logic [BEST_W-1:0] best;
  } near_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLS_WAIT, S_CLS_OUT, S_TRAIN, S_ERR_OUT, S_INIT_RD, S_INIT_WR,
    S_ROUND, S_PT_RD, S_PT_LAT, S_PT_NEAR, S_DIV, S_DIV_WAIT, S_CHG, S_ACC,
    S_CHECK, S_EMIT
  } state_t;

endpackage

// ===== rtl/kmeans_cluster_engine_top.sv =====
// top level of the k-means cluster engine: control sequencer and stores
// depends on kmce_pkg, kmce_point_mem, kmce_near, kmce_div and the defines header
//
// channel | signals                                  | direction
// cfg     | cfg_valid cfg_ready cfg_index cfg_data   | in
// in      | in_valid in_ready req_type coord_a..d final_point | in
// out     | out_valid out_ready result_kind ... run_end       | out
//
// classify: answered by the one-centroid-per-cycle distance pipeline
// load without final mark: stored, the engine stays idle; training: each round reads
// every point from point memory, then the serial divider forms the centroid means
// reset clears control, counters and centroids, no memory sweep
// a stalled output holds the sequencer; cfg is always ready
`include "kmeans_cluster_engine_top_defines.svh"
module kmeans_cluster_engine_top #(
  parameter int MAX_POINTS   = kmce_pkg::MAX_POINTS_DEF,
  parameter int MAX_CLUSTERS = kmce_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_DIMS     = kmce_pkg::MAX_DIMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kmce_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [kmce_pkg::CFG_DW-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic signed [15:0]            coord_a,
  input  logic signed [15:0]            coord_b,
  input  logic signed [15:0]            coord_c,
  input  logic signed [15:0]            coord_d,
  input  logic                          final_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    result_kind,
  output logic [3:0]                    cluster_index,
  output logic signed [15:0]            center_a,
  output logic signed [15:0]            center_b,
  output logic signed [15:0]            center_c,
  output logic signed [15:0]            center_d,
  output logic [7:0]                    rounds_done,
  output logic                          run_end
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int SUMW = kmce_pkg::CW + AW;
  localparam int KW   = $clog2(MAX_CLUSTERS);
  localparam int CHW  = kmce_pkg::SQW + 2 + KW;

  kmce_pkg::state_t state, state_next;

  logic [4:0]  k_setting;
  logic [7:0]  iteration_limit;
  logic [2:0]  dims_in_use;
  logic [15:0] converge_limit;

  logic [KW:0]   k_eff;
  logic [2:0]    d_eff;

  logic [CNTW-1:0] points_loaded, n_pts, pi;
  logic [7:0]      round_counter;
  logic [KW:0]     ci;
  logic [1:0]      dj;
  kmce_pkg::point_t pt;

  kmce_pkg::point_t cent  [MAX_CLUSTERS];
  kmce_pkg::point_t fresh [MAX_CLUSTERS];
  logic [kmce_pkg::NDIM-1:0][SUMW-1:0] sums [MAX_CLUSTERS];
  logic [CNTW-1:0]        cnts [MAX_CLUSTERS];

  logic signed [kmce_pkg::CW-1:0]   fv;
  logic [kmce_pkg::SQW-1:0]         sq;
  logic [CHW-1:0]                   change;
  logic [KW-1:0]                    cls_best;

  logic             in_fire, slot_free, load_out;
  kmce_pkg::point_t in_pt, mem_rd;
  logic             mem_we;
  logic [AW-1:0]    mem_raddr;

  logic                  near_start;
  kmce_pkg::point_t      near_pt;
  logic [KW-1:0]         near_idx;
  kmce_pkg::near_stat_t  near_st;
  logic [KW-1:0]         near_best;

  logic                           div_start, div_done, div_needed;
  logic signed [kmce_pkg::CW-1:0] div_q;
  logic signed [kmce_pkg::DIFW-1:0] chg_diff;
  logic [KW-1:0]                  cidx;

  assign cidx      = ci[KW-1:0];
  assign in_pt     = {coord_d, coord_c, coord_b, coord_a};
  assign in_ready  = (state == kmce_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;
  assign near_best = near_st.best[KW-1:0];

  always_comb begin
    if (k_setting == 5'd0) begin
      k_eff = (KW + 1)'(1);
    end else if (32'(k_setting) > MAX_CLUSTERS) begin
      k_eff = (KW + 1)'(MAX_CLUSTERS);
    end else begin
      k_eff = (KW + 1)'(k_setting);
    end
    if (dims_in_use == 3'd0) begin
      d_eff = 3'd1;
    end else if (32'(dims_in_use) > MAX_DIMS) begin
      d_eff = 3'(MAX_DIMS);
    end else begin
      d_eff = dims_in_use;
    end
  end

  assign mem_we     = in_fire && !req_type && (32'(points_loaded) < MAX_POINTS);
  assign mem_raddr  = (state == kmce_pkg::S_INIT_RD) ? AW'(ci) : pi[AW-1:0];
  assign near_start = (in_fire && req_type) || (state == kmce_pkg::S_PT_LAT);
  assign near_pt    = (state == kmce_pkg::S_IDLE) ? in_pt : mem_rd;
  assign div_needed = (3'(dj) < d_eff) && (cnts[cidx] != '0);
  assign div_start  = (state == kmce_pkg::S_DIV) && div_needed;
  assign chg_diff   = kmce_pkg::DIFW'(fv) - kmce_pkg::DIFW'($signed(cent[cidx][dj]));

  kmce_point_mem #(.DEPTH(MAX_POINTS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (points_loaded[AW-1:0]),
    .wdata (in_pt),
    .raddr (mem_raddr),
    .rdata (mem_rd)
  );

  kmce_near #(.MAX_CLUSTERS(MAX_CLUSTERS), .KW(KW)) u_near (
    .clk    (clk),
    .rst    (rst),
    .start  (near_start),
    .point  (near_pt),
    .k_eff  (k_eff),
    .d_eff  (d_eff),
    .cent   (cent[near_idx]),
    .idx_rd (near_idx),
    .stat   (near_st)
  );

  kmce_div #(.SUMW(SUMW), .CNTW(CNTW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sums[cidx][dj]),
    .divisor  (cnts[cidx]),
    .done     (div_done),
    .quot     (div_q)
  );

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    case (state)
      kmce_pkg::S_IDLE: begin
        if (in_fire && req_type) begin
          state_next = kmce_pkg::S_CLS_WAIT;
        end else if (in_fire && final_point) begin
          state_next = kmce_pkg::S_TRAIN;
        end
      end
      kmce_pkg::S_CLS_WAIT: if (near_st.done) state_next = kmce_pkg::S_CLS_OUT;
      kmce_pkg::S_CLS_OUT: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = kmce_pkg::S_IDLE;
        end
      end
      kmce_pkg::S_TRAIN: begin
        if (32'(n_pts) < 32'(k_eff)) state_next = kmce_pkg::S_ERR_OUT;
        else state_next = kmce_pkg::S_INIT_RD;
      end
      kmce_pkg::S_ERR_OUT: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = kmce_pkg::S_IDLE;
        end
      end
      kmce_pkg::S_INIT_RD: state_next = kmce_pkg::S_INIT_WR;
      kmce_pkg::S_INIT_WR: begin
        if (ci + 1'b1 == k_eff) state_next = kmce_pkg::S_ROUND;
        else state_next = kmce_pkg::S_INIT_RD;
      end
      kmce_pkg::S_ROUND: begin
        if (round_counter >= iteration_limit) state_next = kmce_pkg::S_EMIT;
        else state_next = kmce_pkg::S_PT_RD;
      end
      kmce_pkg::S_PT_RD: state_next = kmce_pkg::S_PT_LAT;
      kmce_pkg::S_PT_LAT: state_next = kmce_pkg::S_PT_NEAR;
      kmce_pkg::S_PT_NEAR: begin
        if (near_st.done) begin
          if (pi + 1'b1 == n_pts) state_next = kmce_pkg::S_DIV;
          else state_next = kmce_pkg::S_PT_RD;
        end
      end
      kmce_pkg::S_DIV: begin
        if (div_needed) state_next = kmce_pkg::S_DIV_WAIT;
        else state_next = kmce_pkg::S_CHG;
      end
      kmce_pkg::S_DIV_WAIT: if (div_done) state_next = kmce_pkg::S_CHG;
      kmce_pkg::S_CHG: state_next = kmce_pkg::S_ACC;
      kmce_pkg::S_ACC: begin
        if (dj == 2'd3 && ci + 1'b1 == k_eff) state_next = kmce_pkg::S_CHECK;
        else state_next = kmce_pkg::S_DIV;
      end
      kmce_pkg::S_CHECK: begin
        if (change < CHW'(converge_limit)) state_next = kmce_pkg::S_EMIT;
        else state_next = kmce_pkg::S_ROUND;
      end
      kmce_pkg::S_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          if (ci + 1'b1 == k_eff) state_next = kmce_pkg::S_IDLE;
        end
      end
      default: state_next = kmce_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmce_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_setting       <= 5'd2;
      iteration_limit <= 8'd10;
      dims_in_use     <= 3'd4;
      converge_limit  <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kmce_pkg::CFG_CLUSTERS: k_setting       <= cfg_data[4:0];
        kmce_pkg::CFG_ITER:     iteration_limit <= cfg_data[7:0];
        kmce_pkg::CFG_DIMS:     dims_in_use     <= cfg_data[2:0];
        kmce_pkg::CFG_CONV:     converge_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_loaded <= '0;
      round_counter <= '0;
      out_valid     <= 1'b0;
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        cent[c] <= '0;
      end
    end else begin
      if (out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      if (near_start) begin
        pt <= near_pt;
      end
      case (state)
        kmce_pkg::S_IDLE: begin
          if (in_fire && !req_type) begin
            if (final_point) begin
              n_pts         <= mem_we ? points_loaded + 1'b1 : points_loaded;
              points_loaded <= '0;
            end else if (mem_we) begin
              points_loaded <= points_loaded + 1'b1;
            end
          end
        end
        kmce_pkg::S_CLS_WAIT: if (near_st.done) cls_best <= near_best;
        kmce_pkg::S_TRAIN: ci <= '0;
        kmce_pkg::S_INIT_WR: begin
          for (int j = 0; j < kmce_pkg::NDIM; j++) begin
            cent[cidx][j] <= (3'(j) < d_eff) ? mem_rd[j] : '0;
          end
          ci <= ci + 1'b1;
          round_counter <= '0;
        end
        kmce_pkg::S_ROUND: begin
          pi     <= '0;
          ci     <= '0;
          dj     <= '0;
          change <= '0;
          for (int c = 0; c < MAX_CLUSTERS; c++) begin
            cnts[c] <= '0;
            sums[c] <= '0;
          end
        end
        kmce_pkg::S_PT_NEAR: begin
          if (near_st.done) begin
            cnts[near_best] <= cnts[near_best] + 1'b1;
            for (int j = 0; j < kmce_pkg::NDIM; j++) begin
              sums[near_best][j] <= sums[near_best][j] + SUMW'($signed(pt[j]));
            end
            pi <= pi + 1'b1;
          end
        end
        kmce_pkg::S_DIV: if (!div_needed) fv <= '0;
        kmce_pkg::S_DIV_WAIT: if (div_done) fv <= div_q;
        kmce_pkg::S_CHG: begin
          fresh[cidx][dj] <= fv;
          if (3'(dj) < d_eff) begin
            sq <= chg_diff * chg_diff;
          end else begin
            sq <= '0;
          end
        end
        kmce_pkg::S_ACC: begin
          change <= change + CHW'(sq);
          dj     <= dj + 1'b1;
          if (dj == 2'd3) begin
            ci <= ci + 1'b1;
          end
        end
        kmce_pkg::S_CHECK: begin
          if (change >= CHW'(converge_limit)) begin
            for (int c = 0; c < MAX_CLUSTERS; c++) begin
              if (32'(c) < 32'(k_eff)) begin
                cent[c] <= fresh[c];
              end
            end
            round_counter <= round_counter + 1'b1;
          end else begin
            ci <= '0;
          end
        end
        kmce_pkg::S_EMIT: if (slot_free) ci <= ci + 1'b1;
        default: ;
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      case (state)
        kmce_pkg::S_CLS_OUT: begin
          result_kind   <= kmce_pkg::KIND_CLASS;
          cluster_index <= 4'(cls_best);
          {center_d, center_c, center_b, center_a} <= cent[cls_best];
          rounds_done   <= round_counter;
          run_end       <= 1'b1;
        end
        kmce_pkg::S_EMIT: begin
          result_kind   <= kmce_pkg::KIND_CENTER;
          cluster_index <= 4'(ci);
          {center_d, center_c, center_b, center_a} <= cent[cidx];
          rounds_done   <= round_counter;
          run_end       <= (ci + 1'b1 == k_eff);
        end
        default: begin
          result_kind   <= kmce_pkg::KIND_ERROR;
          cluster_index <= '0;
          {center_d, center_c, center_b, center_a} <= '0;
          rounds_done   <= '0;
          run_end       <= 1'b1;
        end
      endcase
    end
  end

  `KMCE_ASSERT_SAME(a_err_ends_run, out_valid && result_kind == kmce_pkg::KIND_ERROR, run_end)
  `KMCE_ASSERT_SAME(a_pts_bound, 1'b1, 32'(points_loaded) <= MAX_POINTS)
  `KMCE_ASSERT_SAME(a_best_in_range, near_st.done, 32'(near_best) < 32'(k_eff))
  `KMCE_ASSERT_NEXT(a_final_starts, in_fire && !req_type && final_point, points_loaded == '0)

endmodule

// ===== rtl/kmce_point_mem.sv =====
// training point memory, one write and one registered read port
// depends on kmce_pkg
module kmce_point_mem #(
  parameter int DEPTH = kmce_pkg::MAX_POINTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  kmce_pkg::point_t    wdata,
  input  logic [AW-1:0]       raddr,
  output kmce_pkg::point_t    rdata
);

  kmce_pkg::point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kmce_near.sv =====
// nearest centroid search, one centroid issued per cycle, three stages
// depends on kmce_pkg
module kmce_near #(
  parameter int MAX_CLUSTERS = kmce_pkg::MAX_CLUSTERS_DEF,
  parameter int KW           = $clog2(MAX_CLUSTERS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  kmce_pkg::point_t      point,
  input  logic [KW:0]           k_eff,
  input  logic [2:0]            d_eff,
  input  kmce_pkg::point_t      cent,
  output logic [KW-1:0]         idx_rd,
  output kmce_pkg::near_stat_t  stat
);

  logic                                busy;
  logic [KW:0]                         idx;
  kmce_pkg::point_t                    pt;
  logic                                v1, v2;
  logic [KW-1:0]                       tag1, tag2;
  logic signed [kmce_pkg::DIFW-1:0]    diff1 [kmce_pkg::NDIM];
  logic [kmce_pkg::SQW-1:0]            sq2   [kmce_pkg::NDIM];
  logic [kmce_pkg::DISTW-1:0]          dsum, bestd;
  logic [KW-1:0]                       best;
  logic                                done;
  logic                                issue;

  assign issue  = busy && (idx < k_eff);
  assign idx_rd = idx[KW-1:0];

  always_comb begin
    dsum = '0;
    for (int j = 0; j < kmce_pkg::NDIM; j++) begin
      dsum = dsum + kmce_pkg::DISTW'(sq2[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
        pt   <= point;
      end else if (issue) begin
        idx <= idx + 1'b1;
        if (idx + 1'b1 == k_eff) begin
          busy <= 1'b0;
        end
      end
      v1   <= issue;
      tag1 <= idx[KW-1:0];
      for (int j = 0; j < kmce_pkg::NDIM; j++) begin
        if (3'(j) < d_eff) begin
          diff1[j] <= kmce_pkg::DIFW'($signed(pt[j])) - kmce_pkg::DIFW'($signed(cent[j]));
        end else begin
          diff1[j] <= '0;
        end
      end
      v2   <= v1;
      tag2 <= tag1;
      for (int j = 0; j < kmce_pkg::NDIM; j++) begin
        sq2[j] <= diff1[j] * diff1[j];
      end
      done <= v2 && ((KW + 1)'(tag2) + 1'b1 == k_eff);
      if (v2 && (tag2 == '0 || dsum < bestd)) begin
        best  <= tag2;
        bestd <= dsum;
      end
    end
  end

  assign stat.done = done;
  assign stat.best = kmce_pkg::BEST_W'(best);

endmodule

// ===== rtl/kmce_div.sv =====
// restoring divider for centroid means, one quotient bit per cycle
// depends on kmce_pkg; quotient truncates toward zero
module kmce_div #(
  parameter int SUMW = 26,
  parameter int CNTW = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SUMW-1:0]     dividend,
  input  logic [CNTW-1:0]            divisor,
  output logic                       done,
  output logic signed [kmce_pkg::CW-1:0] quot
);

  localparam int NW = $clog2(SUMW + 1);

  logic            busy;
  logic [NW-1:0]   cnt;
  logic [CNTW-1:0] rem, dv;
  logic [SUMW-1:0] q;
  logic            neg;
  logic [CNTW:0]   rem_sh;
  logic            ge;

  assign rem_sh = {rem, q[SUMW-1]};
  assign ge     = rem_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= NW'(SUMW);
        rem  <= '0;
        dv   <= divisor;
        neg  <= dividend[SUMW-1];
        q    <= dividend[SUMW-1] ? SUMW'(-dividend) : SUMW'(dividend);
      end else if (busy) begin
        rem <= ge ? CNTW'(rem_sh - {1'b0, dv}) : rem_sh[CNTW-1:0];
        q   <= {q[SUMW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -$signed(q[kmce_pkg::CW-1:0]) : $signed(q[kmce_pkg::CW-1:0]);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for kmeans_cluster_engine_top: directed and random load and
// classify traffic, checked against a k-means predictor kept inside this module
// depends on kmce_pkg and the engine rtl
module tb;

  localparam int NPTS = 1024;
  localparam int NCL = 16;
  localparam int HOLD_CYCLES = 500;
  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 440;
  localparam logic [kmce_pkg::CFG_IW-1:0] CFG_UNUSED = 3'd6;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  typedef struct packed {
    logic             req;
    kmce_pkg::point_t crd;
    logic             fin;
  } request_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [3:0]       idx;
    kmce_pkg::point_t crd;
    logic [7:0]       rounds;
    logic             last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [kmce_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [kmce_pkg::CFG_DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic signed [15:0] coord_a = '0, coord_b = '0, coord_c = '0, coord_d = '0;
  logic final_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] result_kind;
  logic [3:0] cluster_index;
  logic signed [15:0] center_a, center_b, center_c, center_d;
  logic [7:0] rounds_done;
  logic run_end;

  kmeans_cluster_engine_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  kmce_pkg::point_t pts [NPTS];
  kmce_pkg::point_t cents [NCL];
  int unsigned loaded = 0;
  int unsigned round_cnt = 0;
  logic [4:0] set_k = 5'd2;
  logic [7:0] set_iter = 8'd10;
  logic [2:0] set_dims = 3'd4;
  logic [15:0] set_conv = 16'd1;

  request_t pending_requests[$];
  result_t expected_results[$];
  request_t cur_req;
  bit in_fire = 0, out_fire = 0, hold_request = 0;
  bit tx_steady = 0, rx_steady = 0;
  int gap_left = 0, stall_left = 0, hold_left = 0;
  int errors = 0, idle_cycles = 0, random_count = 0;

  function automatic int unsigned eff_k();
    if (set_k == 0) return 1;
    if (set_k > NCL) return NCL;
    return set_k;
  endfunction

  function automatic int unsigned eff_d();
    if (set_dims == 0) return 1;
    if (set_dims > 4) return 4;
    return set_dims;
  endfunction

  function automatic longint sq_distance(kmce_pkg::point_t a, kmce_pkg::point_t b,
                                         int unsigned d);
    longint acc, diff;
    acc = 0;
    for (int j = 0; j < d; j++) begin
      diff = longint'($signed(a[j])) - longint'($signed(b[j]));
      acc += diff * diff;
    end
    return acc;
  endfunction

  function automatic int unsigned nearest_center(kmce_pkg::point_t p);
    int unsigned best;
    longint bd, dd;
    best = 0;
    bd = sq_distance(p, cents[0], eff_d());
    for (int c = 1; c < eff_k(); c++) begin
      dd = sq_distance(p, cents[c], eff_d());
      if (dd < bd) begin
        bd = dd;
        best = c;
      end
    end
    return best;
  endfunction

  function automatic void run_training();
    int unsigned n, k, d, a;
    longint sums [NCL][4];
    int unsigned cnt [NCL];
    kmce_pkg::point_t fresh [NCL];
    longint change;
    result_t r;
    n = loaded;
    k = eff_k();
    d = eff_d();
    loaded = 0;
    r = '0;
    if (n < k) begin
      r.kind = kmce_pkg::KIND_ERROR;
      r.last = 1'b1;
      expected_results.push_back(r);
      return;
    end
    for (int c = 0; c < k; c++)
      for (int j = 0; j < 4; j++)
        cents[c][j] = (j < d) ? pts[c][j] : 16'd0;
    round_cnt = 0;
    while (round_cnt < set_iter) begin
      for (int c = 0; c < NCL; c++) begin
        cnt[c] = 0;
        for (int j = 0; j < 4; j++) sums[c][j] = 0;
      end
      for (int i = 0; i < n; i++) begin
        a = nearest_center(pts[i]);
        cnt[a]++;
        for (int j = 0; j < d; j++) sums[a][j] += longint'($signed(pts[i][j]));
      end
      change = 0;
      for (int c = 0; c < k; c++) begin
        for (int j = 0; j < 4; j++) begin
          if (j < d && cnt[c] > 0) fresh[c][j] = 16'(sums[c][j] / longint'(cnt[c]));
          else fresh[c][j] = 16'd0;
        end
        change += sq_distance(fresh[c], cents[c], d);
      end
      if (change < longint'(set_conv)) break;
      for (int c = 0; c < k; c++) cents[c] = fresh[c];
      round_cnt++;
    end
    for (int c = 0; c < k; c++) begin
      r.kind = kmce_pkg::KIND_CENTER;
      r.idx = 4'(c);
      r.crd = cents[c];
      r.rounds = 8'(round_cnt);
      r.last = (c == k - 1);
      expected_results.push_back(r);
    end
  endfunction

  function automatic void predict_request(request_t q);
    int unsigned a;
    result_t r;
    if (q.req == REQ_CLASSIFY) begin
      a = nearest_center(q.crd);
      r.kind = kmce_pkg::KIND_CLASS;
      r.idx = 4'(a);
      r.crd = cents[a];
      r.rounds = 8'(round_cnt);
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      if (loaded < NPTS) begin
        pts[loaded] = q.crd;
        loaded++;
      end
      if (q.fin) run_training();
    end
  endfunction

  function automatic void apply_setting(logic [kmce_pkg::CFG_IW-1:0] idx,
                                        logic [kmce_pkg::CFG_DW-1:0] data);
    case (idx)
      kmce_pkg::CFG_CLUSTERS: set_k = data[4:0];
      kmce_pkg::CFG_ITER:     set_iter = data[7:0];
      kmce_pkg::CFG_DIMS:     set_dims = data[2:0];
      kmce_pkg::CFG_CONV:     set_conv = data[15:0];
      default: ;
    endcase
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_result();
    result_t got, want;
    got.kind = result_kind;
    got.idx = cluster_index;
    got.crd[0] = center_a;
    got.crd[1] = center_b;
    got.crd[2] = center_c;
    got.crd[3] = center_d;
    got.rounds = rounds_done;
    got.last = run_end;
    if (expected_results.size() == 0) begin
      note_error($sformatf("unexpected result kind %0d idx %0d", got.kind, got.idx));
      return;
    end
    want = expected_results.pop_front();
    if (got !== want)
      note_error($sformatf(
        {"exp kind %0d idx %0d c %h rounds %0d end %0b / ",
         "got kind %0d idx %0d c %h rounds %0d end %0b"},
        want.kind, want.idx, want.crd, want.rounds, want.last,
        got.kind, got.idx, got.crd, got.rounds, got.last));
  endfunction

  // sample side
  always @(posedge clk) begin
    in_fire = !rst && in_valid && in_ready;
    out_fire = !rst && out_valid && out_ready;
    if (in_fire) predict_request(cur_req);
    if (out_fire) check_result();
    if (rst || in_fire || out_fire || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        cur_req = pending_requests.pop_front();
        req_type <= cur_req.req;
        coord_a <= cur_req.crd[0];
        coord_b <= cur_req.crd[1];
        coord_c <= cur_req.crd[2];
        coord_d <= cur_req.crd[3];
        final_point <= cur_req.fin;
        in_valid <= 1'b1;
        if ($urandom_range(0, 20) == 0) tx_steady = !tx_steady;
        gap_left = tx_steady ? 0 : $urandom_range(0, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 0;
    end
    if (out_fire) begin
      if ($urandom_range(0, 20) == 0) rx_steady = !rx_steady;
      stall_left = rx_steady ? 0 : $urandom_range(0, 18);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [kmce_pkg::CFG_IW-1:0] idx,
                           logic [kmce_pkg::CFG_DW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_setting(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_settings(int k, int iter, int dims, int conv);
    write_reg(kmce_pkg::CFG_CLUSTERS, 16'(k));
    write_reg(kmce_pkg::CFG_ITER, 16'(iter));
    write_reg(kmce_pkg::CFG_DIMS, 16'(dims));
    write_reg(kmce_pkg::CFG_CONV, 16'(conv));
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void add_request(logic req, kmce_pkg::point_t p, logic fin);
    request_t q;
    q.req = req;
    q.crd = p;
    q.fin = fin;
    pending_requests.push_back(q);
  endfunction

  function automatic kmce_pkg::point_t near_point(kmce_pkg::point_t base, int sp);
    kmce_pkg::point_t p;
    for (int j = 0; j < 4; j++)
      p[j] = 16'(int'($signed(base[j])) + int'($urandom_range(0, 2 * sp)) - sp);
    return p;
  endfunction

  function automatic kmce_pkg::point_t rand_point();
    kmce_pkg::point_t p;
    for (int j = 0; j < 4; j++) p[j] = 16'($urandom);
    return p;
  endfunction

  function automatic int fill_block();
    kmce_pkg::point_t bases [NCL];
    int kef, n, sp, cnt;
    cnt = 0;
    kef = eff_k();
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < 10; i++)
        add_request(1'($urandom), rand_point(), $urandom_range(0, 7) == 0);
      return 10;
    end
    sp = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 600);
    for (int c = 0; c < NCL; c++) bases[c] = rand_point();
    for (int i = $urandom_range(0, 3); i > 0; i--) begin
      add_request(REQ_CLASSIFY, rand_point(), 1'($urandom));
      cnt++;
    end
    n = ($urandom_range(0, 7) == 0 && kef > 1) ? kef - 1 : $urandom_range(kef, kef + 24);
    for (int i = 0; i < n; i++) begin
      add_request(REQ_LOAD, near_point(bases[$urandom_range(0, kef - 1)], sp), i == n - 1);
      cnt++;
    end
    for (int i = $urandom_range(4, 10); i > 0; i--) begin
      add_request(REQ_CLASSIFY, near_point(bases[$urandom_range(0, kef - 1)], sp), 1'b0);
      cnt++;
    end
    return cnt;
  endfunction

  initial begin
    int k, iter, dims, conv, kef, blocks;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: zero centroids, ties go to cluster zero
    add_request(REQ_CLASSIFY, {4{16'h7fff}}, 1'b0);
    add_request(REQ_CLASSIFY, {4{16'h8000}}, 1'b1);
    add_request(REQ_CLASSIFY, {16'h8000, 16'h7fff, 16'h0000, 16'hffff}, 1'b0);
    // too few points
    add_request(REQ_LOAD, {4{16'h1234}}, 1'b1);
    // extreme training set
    add_request(REQ_LOAD, {4{16'h8000}}, 1'b0);
    add_request(REQ_LOAD, {4{16'h7fff}}, 1'b0);
    add_request(REQ_LOAD, {4{16'h0000}}, 1'b0);
    add_request(REQ_LOAD, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, 1'b1);
    add_request(REQ_CLASSIFY, {4{16'h7ff0}}, 1'b0);
    add_request(REQ_CLASSIFY, {4{16'h8010}}, 1'b0);
    add_request(REQ_CLASSIFY, {16'h8000, 16'h7fff, 16'h8000, 16'h8000}, 1'b0);
    wait_idle();
    write_reg(CFG_UNUSED, 16'hffff);
    write_settings(3, 0, 2, 0);
    for (int i = 0; i < 4; i++) add_request(REQ_LOAD, rand_point(), i == 3);
    add_request(REQ_CLASSIFY, rand_point(), 1'b0);
    add_request(REQ_CLASSIFY, rand_point(), 1'b0);
    wait_idle();

    blocks = 0;
    while (random_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: k = 0;
        1: k = 1;
        2: k = 2;
        3: k = 16;
        4: k = 31;
        default: k = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 5))
        0: dims = 0;
        1: dims = 1;
        2: dims = 4;
        3: dims = 7;
        default: dims = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 4))
        0: conv = 0;
        1: conv = 1;
        2: conv = 65535;
        default: conv = $urandom_range(0, 4000);
      endcase
      kef = (k == 0) ? 1 : (k > 16 ? 16 : k);
      if (kef > 8) iter = $urandom_range(1, 12);
      else case ($urandom_range(0, 4))
        0: iter = 0;
        1: iter = 255;
        default: iter = $urandom_range(1, 20);
      endcase
      if (iter == 255 && (kef > 2 || conv == 0)) iter = 20;
      if (conv == 0 && iter > 8) iter = $urandom_range(0, 8);
      write_settings(k, iter, dims, conv);
      if (blocks == 3) hold_request = 1;
      random_count += fill_block();
      blocks++;
      wait_idle();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
